FILE: rtl/core/vsl_pkg.sv
// Shared types, constants and register codes for the three-axis slew limiter
`timescale 1ns / 1ps

package vsl_pkg;

  // field widths
  localparam int unsigned VelWidth     = 16;
  localparam int unsigned StepWidth    = 15;
  localparam int unsigned AgeWidth     = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned NumAxes      = 3;

  // working width for magnitudes, differences and steps
  localparam int unsigned WideWidth =
      ((VelWidth + 1 > StepWidth) ? VelWidth + 1 : StepWidth) + 1;

  typedef logic signed [VelWidth-1:0]  vel_t;
  typedef logic signed [WideWidth-1:0] wide_t;
  typedef logic [StepWidth-1:0]        step_t;
  typedef logic [AgeWidth-1:0]         age_t;
  typedef logic [CfgDataWidth-1:0]     cfg_data_t;

  // request kinds
  typedef enum logic {
    ReqCommand = 1'b0,
    ReqTick    = 1'b1
  } req_type_e;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    RegLinAccel = 3'd0,
    RegLinDecel = 3'd1,
    RegAngAccel = 3'd2,
    RegAngDecel = 3'd3,
    RegTimeout  = 3'd4,
    RegLimitEn  = 3'd5
  } cfg_reg_e;

  // configuration register set
  typedef struct packed {
    step_t lin_accel;
    step_t lin_decel;
    step_t ang_accel;
    step_t ang_decel;
    age_t  timeout;
    logic  limit_en;
  } cfg_t;

  // reset values
  localparam step_t StepReset    = step_t'(10);
  localparam age_t  TimeoutReset = age_t'(20);
  localparam age_t  AgeStale     = '1;

endpackage

FILE: rtl/core/velocity_slew_limiter_3axis_top.sv
// Top level of the three-axis velocity slew limiter
`timescale 1ns / 1ps
// An item enters the input register and is processed from there; a tick that emits loads
// its result into the result register. Throughput: one item per cycle, set by the single
// register-to-register slew pass, unless a staged tick stalls on the result register.
// A staged tick that must emit waits only while the result register holds an untaken item.
// Reset clears held command and previous output to zero, marks the command stale,
// and loads the step, timeout and enable registers with their defaults.

module velocity_slew_limiter_3axis_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  vsl_pkg::vel_t                   cmd_linear_x_i,
  input  vsl_pkg::vel_t                   cmd_linear_y_i,
  input  vsl_pkg::vel_t                   cmd_angular_z_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vsl_pkg::vel_t                   out_linear_x_o,
  output vsl_pkg::vel_t                   out_linear_y_o,
  output vsl_pkg::vel_t                   out_angular_z_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vsl_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  vsl_pkg::cfg_data_t              cfg_data_i
);

  vsl_pkg::cfg_t cfg;

  // input register
  logic          stg_valid_q, stg_valid_d;
  logic          stg_type_q;
  vsl_pkg::vel_t stg_cmd_q [vsl_pkg::NumAxes];

  // block state
  vsl_pkg::vel_t held_q [vsl_pkg::NumAxes];
  vsl_pkg::vel_t prev_q [vsl_pkg::NumAxes];
  vsl_pkg::age_t age_q, age_next;

  // result register
  logic          out_valid_q, out_valid_d;
  vsl_pkg::vel_t out_q [vsl_pkg::NumAxes];

  logic          is_tick, fresh, moving, emit, stg_fire, in_fire, out_free;
  vsl_pkg::vel_t target [vsl_pkg::NumAxes];
  vsl_pkg::vel_t res    [vsl_pkg::NumAxes];

  vsl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // freshness and emit decision
  always_comb begin
    is_tick  = (stg_type_q == vsl_pkg::ReqTick);
    age_next = (age_q == vsl_pkg::AgeStale) ? age_q : age_q + 1'b1;
    fresh    = (age_next != vsl_pkg::AgeStale) && (age_next <= cfg.timeout);
    moving   = (prev_q[0] != '0) || (prev_q[1] != '0) || (prev_q[2] != '0);
    emit     = is_tick && (fresh || moving);
    for (int i = 0; i < vsl_pkg::NumAxes; i++) begin
      target[i] = fresh ? held_q[i] : '0;
    end
  end

  // slew units
  vsl_axis u_axis_x (
    .target_i   (target[0]),
    .prev_i     (prev_q[0]),
    .accel_i    (cfg.lin_accel),
    .decel_i    (cfg.lin_decel),
    .limit_en_i (cfg.limit_en),
    .res_o      (res[0])
  );

  vsl_axis u_axis_y (
    .target_i   (target[1]),
    .prev_i     (prev_q[1]),
    .accel_i    (cfg.lin_accel),
    .decel_i    (cfg.lin_decel),
    .limit_en_i (cfg.limit_en),
    .res_o      (res[1])
  );

  vsl_axis u_axis_z (
    .target_i   (target[2]),
    .prev_i     (prev_q[2]),
    .accel_i    (cfg.ang_accel),
    .decel_i    (cfg.ang_decel),
    .limit_en_i (cfg.limit_en),
    .res_o      (res[2])
  );

  // handshake: the staged item moves on unless its result has nowhere to go
  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    stg_fire    = stg_valid_q && (!emit || out_free);
    in_ready_o  = !stg_valid_q || stg_fire;
    in_fire     = in_valid_i && in_ready_o;
    stg_valid_d = in_fire || (stg_valid_q && !stg_fire);
    out_valid_d = (stg_fire && emit) || (out_valid_q && !out_ready_i);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      age_q       <= vsl_pkg::AgeStale;
      for (int i = 0; i < vsl_pkg::NumAxes; i++) begin
        held_q[i] <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
      if (stg_fire) begin
        if (!is_tick) begin
          age_q     <= '0;
          held_q[0] <= stg_cmd_q[0];
          held_q[1] <= stg_cmd_q[1];
          held_q[2] <= stg_cmd_q[2];
        end else begin
          age_q <= age_next;
          if (emit) begin
            for (int i = 0; i < vsl_pkg::NumAxes; i++) begin
              prev_q[i] <= res[i];
              if (!fresh) begin
                held_q[i] <= '0;
              end
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_type_q   <= req_type_i;
      stg_cmd_q[0] <= cmd_linear_x_i;
      stg_cmd_q[1] <= cmd_linear_y_i;
      stg_cmd_q[2] <= cmd_angular_z_i;
    end
    if (stg_fire && emit) begin
      for (int i = 0; i < vsl_pkg::NumAxes; i++) begin
        out_q[i] <= res[i];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_linear_x_o  = out_q[0];
  assign out_linear_y_o  = out_q[1];
  assign out_angular_z_o = out_q[2];

`ifndef ASSERT_OFF
  // a processed command restarts the age count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_fire && !is_tick |=> age_q == '0)
    else $error("age not cleared by command item");

  // a tick never makes the command younger
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_fire && is_tick |=> age_q >= $past(age_q))
    else $error("age decreased on tick item");

  // a pending result always matches the previous-output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q[0] == prev_q[0]) && (out_q[1] == prev_q[1]) &&
                    (out_q[2] == prev_q[2]))
    else $error("pending result differs from previous output");

  // a result is never loaded over one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(stg_fire && emit))
    else $error("result register overwritten");
`endif

endmodule

FILE: rtl/core/vsl_cfg.sv
// Configuration register file for the three-axis slew limiter
`timescale 1ns / 1ps

module vsl_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [vsl_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  vsl_pkg::cfg_data_t                   cfg_data_i,
  output vsl_pkg::cfg_t                        cfg_o
);

  vsl_pkg::cfg_t cfg_d, cfg_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register decode, unused indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (vsl_pkg::cfg_reg_e'(cfg_index_i))
        vsl_pkg::RegLinAccel: cfg_d.lin_accel = cfg_data_i[vsl_pkg::StepWidth-1:0];
        vsl_pkg::RegLinDecel: cfg_d.lin_decel = cfg_data_i[vsl_pkg::StepWidth-1:0];
        vsl_pkg::RegAngAccel: cfg_d.ang_accel = cfg_data_i[vsl_pkg::StepWidth-1:0];
        vsl_pkg::RegAngDecel: cfg_d.ang_decel = cfg_data_i[vsl_pkg::StepWidth-1:0];
        vsl_pkg::RegTimeout:  cfg_d.timeout   = cfg_data_i[vsl_pkg::AgeWidth-1:0];
        vsl_pkg::RegLimitEn:  cfg_d.limit_en  = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lin_accel <= vsl_pkg::StepReset;
      cfg_q.lin_decel <= vsl_pkg::StepReset;
      cfg_q.ang_accel <= vsl_pkg::StepReset;
      cfg_q.ang_decel <= vsl_pkg::StepReset;
      cfg_q.timeout   <= vsl_pkg::TimeoutReset;
      cfg_q.limit_en  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/vsl_axis.sv
// Per-axis slew step: moves the previous output toward the target by a bounded step
`timescale 1ns / 1ps

module vsl_axis (
  input  vsl_pkg::vel_t  target_i,
  input  vsl_pkg::vel_t  prev_i,
  input  vsl_pkg::step_t accel_i,
  input  vsl_pkg::step_t decel_i,
  input  logic           limit_en_i,
  output vsl_pkg::vel_t  res_o
);

  vsl_pkg::wide_t tgt_w, prev_w, mag_tgt, mag_prev, dv, mag_dv, step_w, lim_w;

  // magnitudes and difference at full width
  always_comb begin
    tgt_w    = vsl_pkg::wide_t'(target_i);
    prev_w   = vsl_pkg::wide_t'(prev_i);
    mag_tgt  = (tgt_w < 0) ? -tgt_w : tgt_w;
    mag_prev = (prev_w < 0) ? -prev_w : prev_w;
    dv       = tgt_w - prev_w;
    mag_dv   = (dv < 0) ? -dv : dv;
  end

  // accel step when the magnitude does not fall, decel step otherwise
  assign step_w = (mag_tgt >= mag_prev) ? vsl_pkg::wide_t'(accel_i)
                                        : vsl_pkg::wide_t'(decel_i);

  // clamp the move; a clamped result lies between prev and target
  always_comb begin
    if (mag_dv > step_w) begin
      lim_w = (dv > 0) ? prev_w + step_w : prev_w - step_w;
    end else begin
      lim_w = tgt_w;
    end
  end

  assign res_o = limit_en_i ? vsl_pkg::vel_t'(lim_w) : target_i;

endmodule
